// File: sv/sse_pkg.sv
// Shared types and constants for the scanline sprite evaluation block.
// Request/result payloads, command and result codes, controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

	// Default configuration
	localparam int ENTRY_COUNT_DEF    = 64;
	localparam int SLOTS_PER_LINE_DEF = 8;

	// Attribute memory geometry: 64 rows of four byte lanes
	localparam int MEM_ROWS  = 64;
	localparam int ROW_W     = 6;
	localparam int LANES     = 4;
	localparam int LANE_W    = 2;

	// Erased byte value
	localparam logic [7:0] BYTE_ERASED = 8'hFF;

	// Request command codes
	localparam logic [2:0] CMD_SET_ADDR = 3'd0;
	localparam logic [2:0] CMD_WRITE    = 3'd1;
	localparam logic [2:0] CMD_READ     = 3'd2;
	localparam logic [2:0] CMD_EVAL     = 3'd3;
	localparam logic [2:0] CMD_CLR_OVF  = 3'd4;

	// Result kind codes
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_SPRITE = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
		logic [7:0] scanline;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] read_data;
		logic [2:0] slot;
		logic [7:0] sprite_y;
		logic [7:0] sprite_tile;
		logic [7:0] sprite_attr;
		logic [7:0] sprite_x;
		logic [3:0] found_count;
		logic       overflow;
		logic       last;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic set_ptr;
		logic wr_mem;
		logic clr_ovf;
		logic set_ovf;
		logic scan_clr;
		logic addr_ptr;
		logic advance;
		logic emit_read;
		logic emit_sprite;
		logic emit_done;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;
		logic selecting;
		logic last_entry;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/sse_ctrl.sv
// Sequencing controller for scanline sprite evaluation.
// Decodes requests and steps the entry scan; depends on sse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl import sse_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic [2:0] cmd,
	input  wire sts_t sts,
	output logic      req_stall,
	output ctl_t      ctl
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_FETCH_RD = 3'd1;
	localparam logic [2:0] ST_READ_OUT = 3'd2;
	localparam logic [2:0] ST_FETCH_EV = 3'd3;
	localparam logic [2:0] ST_SCAN     = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_SET_ADDR: ctl.set_ptr = 1'b1;
						CMD_WRITE:    ctl.wr_mem  = 1'b1;
						CMD_CLR_OVF:  ctl.clr_ovf = 1'b1;
						CMD_READ:     state_d     = ST_FETCH_RD;
						CMD_EVAL: begin
							ctl.scan_clr = 1'b1;
							state_d      = ST_FETCH_EV;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH_RD: begin
				ctl.addr_ptr = 1'b1;
				state_d      = ST_READ_OUT;
			end
			ST_READ_OUT: begin
				// keep the pointer row in the read register while the result waits
				ctl.addr_ptr = 1'b1;
				if (sts.out_free) begin
					ctl.emit_read = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_FETCH_EV: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.selecting) begin
					// hold on a hit until the result register frees up
					if (!sts.hit || sts.out_free) begin
						ctl.advance     = 1'b1;
						ctl.emit_sprite = sts.hit;
						if (sts.last_entry) begin
							state_d = ST_DONE;
						end
					end
				end else if (sts.hit) begin
					ctl.set_ovf = 1'b1;
					state_d     = ST_DONE;
				end else begin
					ctl.advance = 1'b1;
					if (sts.last_entry) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.emit_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/sse_datapath.sv
// Datapath for scanline sprite evaluation: attribute memory, pointer,
// overflow flag, scan counters, coverage test and result register; uses sse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sse_datapath import sse_pkg::*; #(
	parameter int ENTRY_COUNT    = ENTRY_COUNT_DEF,
	parameter int SLOTS_PER_LINE = SLOTS_PER_LINE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data,
	input  wire ctl_t ctl,
	output sts_t      sts,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int NW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int FW = $clog2(SLOTS_PER_LINE + 1);

	logic             tall_q;
	logic [7:0]       ptr_q;
	logic             ovf_q;
	logic [7:0]       line_q;
	logic [NW-1:0]    chk_q;
	logic [LANE_W-1:0] m_q;
	logic [FW-1:0]    found_q;

	logic [7:0]        mem_lane [LANES][MEM_ROWS];
	logic [MEM_ROWS*LANES-1:0] vld_q;
	logic [7:0]        rd_s1  [LANES];
	logic [LANES-1:0]  rdv_s1;
	logic [7:0]        word   [LANES];
	logic [ROW_W-1:0]  raddr;
	logic [ROW_W-1:0]  wrow;

	logic [7:0]  test_byte;
	logic [8:0]  diff;
	logic        out_valid_q;
	res_t        out_q;
	res_t        out_d;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q <= 1'b0;
		end else if (cfg_wr_en) begin
			tall_q <= cfg_wr_data;
		end
	end

	// Access pointer and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (ctl.set_ptr) begin
				ptr_q <= req.value;
			end else if (ctl.wr_mem) begin
				ptr_q <= ptr_q + 8'd1;
			end
			if (ctl.clr_ovf) begin
				ovf_q <= 1'b0;
			end else if (ctl.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Row address: pointer row for bus reads, else current or next entry
	assign wrow  = ptr_q[7:2];
	assign raddr = ctl.addr_ptr ? wrow :
		(ctl.advance ? ROW_W'(chk_q + 1'b1) : ROW_W'(chk_q));

	// Byte valid bits: an unwritten byte reads as erased
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.wr_mem) begin
			vld_q[ptr_q] <= 1'b1;
		end
	end

	// Four byte-lane memories sharing one row address
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (ctl.wr_mem && (ptr_q[1:0] == LANE_W'(l))) begin
				mem_lane[l][wrow] <= req.value;
			end
			rd_s1[l]  <= mem_lane[l][raddr];
			rdv_s1[l] <= vld_q[{raddr, LANE_W'(l)}];
		end
		assign word[l] = rdv_s1[l] ? rd_s1[l] : BYTE_ERASED;
	end

	// Scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q   <= '0;
			m_q     <= '0;
			found_q <= '0;
		end else if (ctl.scan_clr) begin
			chk_q   <= '0;
			m_q     <= '0;
			found_q <= '0;
		end else if (ctl.advance) begin
			chk_q <= chk_q + 1'b1;
			if (ctl.emit_sprite) begin
				found_q <= found_q + 1'b1;
			end
			// overflow phase walks the byte offset 0,1,2 (hardware quirk)
			if (!sts.selecting) begin
				m_q <= (m_q == LANE_W'(2)) ? '0 : m_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_clr) begin
			line_q <= req.scanline;
		end
	end

	// Coverage test without wrap: y <= line < y + height
	assign test_byte = sts.selecting ? word[0] : word[m_q];
	assign diff      = {1'b0, line_q} - {1'b0, test_byte};

	always_comb begin
		sts.selecting  = (found_q < FW'(SLOTS_PER_LINE));
		sts.last_entry = (chk_q == NW'(ENTRY_COUNT - 1));
		sts.out_free   = !out_valid_q || !res_stall;
		sts.hit        = !diff[8] &&
			(tall_q ? (diff[7:4] == 4'd0) : (diff[7:3] == 5'd0));
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_read || ctl.emit_sprite || ctl.emit_done) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next result: unused fields stay zero
	always_comb begin
		out_d = '0;
		if (ctl.emit_read) begin
			out_d.kind      = KIND_READ;
			out_d.read_data = word[ptr_q[1:0]];
			out_d.last      = 1'b1;
		end else if (ctl.emit_sprite) begin
			out_d.kind        = KIND_SPRITE;
			out_d.slot        = 3'(found_q);
			out_d.sprite_y    = word[0];
			out_d.sprite_tile = word[1];
			out_d.sprite_attr = word[2];
			out_d.sprite_x    = word[3];
		end else begin
			out_d.kind        = KIND_DONE;
			out_d.found_count = 4'(found_q);
			out_d.overflow    = ovf_q;
			out_d.last        = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_read || ctl.emit_sprite || ctl.emit_done) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

// File: sv/scanline_sprite_evaluation.sv
// Scanline sprite evaluation: 256-byte attribute memory with 8-per-line selection.
// A bus read passes the fetch and read-out states before its result is registered;
// set address, write and clear complete on acceptance. Evaluate scans one entry per
// cycle (one row read of the attribute memory per cycle) while no hit waits on a stalled
// result, and stops early when the overflow scan hits. One request at a time is in work.
// Reset (arst_n low) clears pointer, overflow flag, height select and byte valid bits;
// every memory byte then reads as 0xFF until written. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module scanline_sprite_evaluation import sse_pkg::*; #(
	parameter int ENTRY_COUNT    = ENTRY_COUNT_DEF,
	parameter int SLOTS_PER_LINE = SLOTS_PER_LINE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	ctl_t ctl;
	sts_t sts;

	sse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cmd       (req.cmd),
		.sts       (sts),
		.req_stall (req_stall),
		.ctl       (ctl)
	);

	sse_datapath #(
		.ENTRY_COUNT    (ENTRY_COUNT),
		.SLOTS_PER_LINE (SLOTS_PER_LINE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ctl         (ctl),
		.sts         (sts),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	// A read or evaluate request keeps the block busy in the next cycle
	a_busy_after_long_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (req.cmd == CMD_READ || req.cmd == CMD_EVAL))
		|=> req_stall)
		else $error("block not busy after read or evaluate request");

	// Sprite results never end a request; read and done results always do
	a_last_by_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last == (res.kind != KIND_SPRITE)))
		else $error("last flag does not match result kind");

	// Sprites come out only while an evaluation is in progress
	a_sprite_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_SPRITE) |-> req_stall)
		else $error("sprite result outside an evaluation");

	// Commands never collide: at most one emit per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.emit_read, ctl.emit_sprite, ctl.emit_done}))
		else $error("more than one result loaded in a cycle");

endmodule

`default_nettype wire

// File: sim/sse_checker.sv
// Checker for scanline_sprite_evaluation: watches the request, result and config ports,
// predicts results and compares them in order. Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_checker import sse_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_stall,
	input  wire req_t req,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data,
	input  wire logic res_valid,
	input  wire logic res_stall,
	input  wire res_t res,
	output int        mismatches,
	output int        outstanding
);

	localparam int SHORT_HEIGHT = 8;
	localparam int TALL_HEIGHT  = 16;
	localparam int OAM_BYTES    = 256;
	localparam int PRINT_CAP    = 40;

	// Shadow of the block's state
	logic [7:0] oam [OAM_BYTES];
	logic [7:0] oam_ptr;
	logic       ovf_flag;
	logic       tall_mode;

	res_t awaited_results[$];
	res_t want;

	// No wrap: a sprite near the bottom never reaches low lines
	function automatic bit line_covered(logic [7:0] top, logic [7:0] line, int height);
		return int'(line) >= int'(top) && int'(line) < int'(top) + height;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("%0t checker: %s", $time, msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] wanted);
		if (got !== wanted) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, wanted));
		end
	endtask

	// Update shadow state for one request and queue the results it causes
	task automatic apply_request(input req_t r);
		res_t item;
		int   height;
		int   entry;
		int   found;
		int   lane;
		bit   ovf_hit;
		item = '0;
		case (r.cmd)
			CMD_SET_ADDR: oam_ptr = r.value;
			CMD_WRITE: begin
				oam[oam_ptr] = r.value;
				oam_ptr = oam_ptr + 8'd1;
			end
			CMD_READ: begin
				item.kind      = KIND_READ;
				item.read_data = oam[oam_ptr];
				item.last      = 1'b1;
				awaited_results.push_back(item);
			end
			CMD_CLR_OVF: ovf_flag = 1'b0;
			CMD_EVAL: begin
				height = tall_mode ? TALL_HEIGHT : SHORT_HEIGHT;
				entry  = 0;
				found  = 0;
				// Selection: first eight covering entries in order
				while (found < SLOTS_PER_LINE_DEF && entry < ENTRY_COUNT_DEF) begin
					if (line_covered(oam[4 * entry], r.scanline, height)) begin
						item             = '0;
						item.kind        = KIND_SPRITE;
						item.slot        = found[2:0];
						item.sprite_y    = oam[4 * entry];
						item.sprite_tile = oam[4 * entry + 1];
						item.sprite_attr = oam[4 * entry + 2];
						item.sprite_x    = oam[4 * entry + 3];
						awaited_results.push_back(item);
						found++;
					end
					entry++;
				end
				// Overflow scan: byte offset walks 0,1,2 as on the original part
				lane    = 0;
				ovf_hit = 1'b0;
				while (!ovf_hit && entry < ENTRY_COUNT_DEF) begin
					if (line_covered(oam[4 * entry + lane], r.scanline, height)) begin
						ovf_flag = 1'b1;
						ovf_hit  = 1'b1;
					end else begin
						entry++;
						lane = (lane == 2) ? 0 : lane + 1;
					end
				end
				item             = '0;
				item.kind        = KIND_DONE;
				item.found_count = found[3:0];
				item.overflow    = ovf_flag;
				item.last        = 1'b1;
				awaited_results.push_back(item);
			end
			default: ;
		endcase
	endtask

	// Predict on accepted requests, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OAM_BYTES; i++) oam[i] = BYTE_ERASED;
			oam_ptr   = '0;
			ovf_flag  = 1'b0;
			tall_mode = 1'b0;
			awaited_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) tall_mode = cfg_wr_data;
			if (req_valid && !req_stall) apply_request(req);
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited");
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", 8'(res.kind), 8'(want.kind));
					check_field("read_data", res.read_data, want.read_data);
					check_field("slot", 8'(res.slot), 8'(want.slot));
					check_field("sprite_y", res.sprite_y, want.sprite_y);
					check_field("sprite_tile", res.sprite_tile, want.sprite_tile);
					check_field("sprite_attr", res.sprite_attr, want.sprite_attr);
					check_field("sprite_x", res.sprite_x, want.sprite_x);
					check_field("found_count", 8'(res.found_count), 8'(want.found_count));
					check_field("overflow", 8'(res.overflow), 8'(want.overflow));
					check_field("last", 8'(res.last), 8'(want.last));
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// Testbench top for scanline_sprite_evaluation: clock, reset, request and config
// stimulus, result back-pressure and the verdict. Depends on sse_pkg and sse_checker.
`timescale 1ns / 1ps

module tb_top;
	import sse_pkg::*;

	localparam int         CYCLE_LIMIT      = 200000;
	localparam int         DRAIN_CYCLES     = ENTRY_COUNT_DEF + 16;
	localparam int         SETTLE_CYCLES    = 10;
	localparam int         HOLD_CYCLES      = 400;
	localparam int         PHASE_REQUESTS   = 14;
	localparam int         PHASES           = 5;
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic res_valid;
	logic res_stall;
	res_t res;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int requests_sent = 0;
	bit quiet = 1'b0;
	bit hold_long = 1'b0;

	scanline_sprite_evaluation i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	sse_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result back-pressure: random bursts, one long hold-off on request
	initial begin
		res_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Offer one request and hold it until accepted, then maybe go idle
	task automatic issue(input logic [2:0] cmd, input logic [7:0] value,
			input logic [7:0] line);
		req_t r;
		r.cmd      = cmd;
		r.value    = value;
		r.scanline = line;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (cmd <= CMD_CLR_OVF) requests_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Wait for the block to go idle
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_height(input logic tall);
		cfg_wr_data <= tall;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic place_sprite(input logic [5:0] idx, input logic [7:0] y,
			input logic [7:0] tile, input logic [7:0] attr, input logic [7:0] x);
		issue(CMD_SET_ADDR, {idx, 2'b00}, 8'($urandom));
		issue(CMD_WRITE, y, 8'($urandom));
		issue(CMD_WRITE, tile, 8'($urandom));
		issue(CMD_WRITE, attr, 8'($urandom));
		issue(CMD_WRITE, x, 8'($urandom));
	endtask

	// Non-Y bytes sometimes land near the line so the skewed scan can hit them
	function automatic logic [7:0] lure_byte(input logic [7:0] focus);
		return ($urandom_range(0, 2) == 0) ? focus - 8'($urandom_range(0, 7))
		                                   : 8'($urandom);
	endfunction

	// Mostly sprite loads and evaluations around one line, some bus noise
	task automatic run_traffic(input int budget, input logic [7:0] focus);
		int         goal;
		int         pick;
		logic [7:0] y;
		goal = requests_sent + budget;
		while (requests_sent < goal) begin
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				case ($urandom_range(0, 3))
					0:       y = focus - 8'($urandom_range(0, 17));
					1:       y = focus;
					2:       y = 8'($urandom);
					default: y = 8'hF0 | 8'($urandom_range(0, 15));
				endcase
				place_sprite(6'($urandom_range(0, 63)), y, lure_byte(focus),
					lure_byte(focus), lure_byte(focus));
			end else if (pick < 14) begin
				issue(CMD_EVAL, 8'($urandom),
					($urandom_range(0, 4) == 0) ? 8'($urandom) : focus);
			end else if (pick == 14) begin
				issue(CMD_SET_ADDR, 8'($urandom), 8'($urandom));
				issue(CMD_READ, 8'($urandom), 8'($urandom));
			end else if (pick == 15) begin
				issue(CMD_READ, 8'($urandom), 8'($urandom));
			end else if (pick == 16) begin
				issue(CMD_CLR_OVF, 8'($urandom), 8'($urandom));
			end else if (pick == 17) begin
				issue(CMD_UNUSED_FIRST + 3'($urandom_range(0, 2)), 8'($urandom),
					8'($urandom));
			end else if (pick == 18) begin
				issue(CMD_WRITE, 8'($urandom), 8'($urandom));
			end else begin
				issue(CMD_EVAL, 8'($urandom), 8'($urandom));
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		logic [7:0] focus;
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req         <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_height(1'b0);

		// Erased memory: read, no wrap onto line 0, full line 255 with overflow
		issue(CMD_READ, 8'hFF, 8'h00);
		issue(CMD_EVAL, 8'h00, 8'h00);
		issue(CMD_EVAL, 8'hFF, 8'hFF);
		issue(CMD_CLR_OVF, 8'h00, 8'hFF);
		for (int k = 0; k < 3; k++) issue(CMD_UNUSED_FIRST + 3'(k), 8'hFF, 8'h00);
		// Pointer wraps past the top of memory
		issue(CMD_SET_ADDR, 8'hFD, 8'h00);
		issue(CMD_WRITE, 8'h00, 8'hFF);
		issue(CMD_WRITE, 8'hFF, 8'h00);
		issue(CMD_WRITE, 8'h12, 8'h00);
		issue(CMD_WRITE, 8'h34, 8'h00);
		issue(CMD_SET_ADDR, 8'hFF, 8'h00);
		issue(CMD_READ, 8'h00, 8'h00);
		issue(CMD_EVAL, 8'h00, 8'hFF);
		// Height edges for short then tall sprites
		place_sprite(6'd0, 8'h00, 8'h55, 8'hAA, 8'hFF);
		issue(CMD_EVAL, 8'h00, 8'd7);
		issue(CMD_EVAL, 8'h00, 8'd8);
		settle();
		set_height(1'b1);
		issue(CMD_EVAL, 8'h00, 8'd15);
		issue(CMD_EVAL, 8'h00, 8'd16);

		// Random phases, each with its own height and focus line
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0, 3:    set_height(1'b0);
				1, 2:    set_height(1'b1);
				default: set_height(1'($urandom_range(0, 1)));
			endcase
			focus = 8'($urandom);
			if (p == PHASES - 1) quiet = 1'b1;
			if (p == 1) begin
				// Hold results off while evaluations keep coming
				hold_long = 1'b1;
				repeat (4) issue(CMD_EVAL, 8'($urandom), focus);
			end
			run_traffic(PHASE_REQUESTS, focus);
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
sv/sse_pkg.sv
sv/sse_ctrl.sv
sv/sse_datapath.sv
sv/scanline_sprite_evaluation.sv
sim/sse_checker.sv
sim/tb_top.sv
